/* src/deq_pkg.sv */
// Shared types, constants and codes for the double-ended queue.
package deq_pkg;

	localparam int DEPTH  = 64;
	localparam int ELEM_W = 32;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_BACK   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_PEEK_BACK  = 3'd4;
	localparam logic [2:0] REQ_PEEK_FRONT = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] data_in;
	} req_t;

	typedef struct packed {
		logic [31:0] data_out;
		logic [1:0]  status;
		logic [6:0]  fill_count;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

/* src/double_ended_queue.sv */
// Top level of the double-ended queue: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------
//  request  | start, busy          | req  (req_type, data_in)
//  result   | done (one-cycle)     | rsp  (data_out, status, fill_count)
//
// A transaction is taken when start is high and busy is low; its result
// shows on rsp with done while the controller presents the result, and
// busy falls after that state, so a new transaction is taken only once
// the last is through. The three controller states are: take the request,
// execute with a registered memory access, present the result.
// Reset empties the queue at once; memory contents are not cleared.
// The receiver cannot stall: each result is valid for the done cycle only.
module double_ended_queue
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	cmd_t cmd;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	deq_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

/* src/deq_ctrl.sv */
// Controller state machine sequencing one transaction at a time.
module deq_ctrl
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					done_q  <= 1'b1;
				end
				S_RESP: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.exec = (state_q == S_EXEC);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.exec && busy)
		else $error("accepted transaction not executed");

	a_exec_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done)
		else $error("executed transaction gave no result");

endmodule

/* src/deq_dpath.sv */
// Datapath: element memory, front and back pointers, count and result registers.
module deq_dpath
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	logic [ELEM_W-1:0] mem [DEPTH];

	logic [2:0]        req_type_q;
	logic [ELEM_W-1:0] data_q;
	logic [PTR_W-1:0]  front_q;
	logic [PTR_W-1:0]  back_q;
	logic [CNT_W-1:0]  count_q;
	logic [ELEM_W-1:0] rd_data_q;
	logic              rd_valid_q;
	logic [1:0]        status_q;

	logic              full;
	logic              empty;
	logic [PTR_W-1:0]  front_prev;
	logic [PTR_W-1:0]  front_next;
	logic [PTR_W-1:0]  back_prev;
	logic [PTR_W-1:0]  back_next;
	logic              is_push;
	logic              is_back_rd;
	logic              is_front_rd;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic              rd_en;
	logic [PTR_W-1:0]  rd_addr;
	logic [1:0]        status_d;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_prev = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_next = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign back_prev  = (back_q == '0) ? PTR_W'(DEPTH - 1) : back_q - 1'b1;
	assign back_next  = (back_q == PTR_W'(DEPTH - 1)) ? '0 : back_q + 1'b1;

	assign is_push     = (req_type_q == REQ_PUSH_BACK) || (req_type_q == REQ_PUSH_FRONT);
	assign is_back_rd  = (req_type_q == REQ_POP_BACK) || (req_type_q == REQ_PEEK_BACK);
	assign is_front_rd = (req_type_q == REQ_POP_FRONT) || (req_type_q == REQ_PEEK_FRONT);

	assign wr_en   = cmd.exec && is_push && !full;
	assign wr_addr = (req_type_q == REQ_PUSH_FRONT) ? front_prev : back_q;
	assign rd_en   = cmd.exec && (is_back_rd || is_front_rd) && !empty;
	assign rd_addr = is_back_rd ? back_prev : front_q;

	always_comb begin
		status_d = ST_OK;
		if (is_push && full) begin
			status_d = ST_FULL;
		end else if ((is_back_rd || is_front_rd) && empty) begin
			status_d = ST_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= data_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (cmd.load) begin
			req_type_q <= req.req_type;
			data_q     <= req.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			back_q     <= '0;
			count_q    <= '0;
			rd_valid_q <= 1'b0;
			status_q   <= ST_OK;
		end else if (cmd.exec) begin
			rd_valid_q <= rd_en;
			status_q   <= status_d;
			if (wr_en) begin
				count_q <= count_q + 1'b1;
				if (req_type_q == REQ_PUSH_FRONT) begin
					front_q <= front_prev;
				end else begin
					back_q <= back_next;
				end
			end else if (rd_en && (req_type_q == REQ_POP_BACK)) begin
				back_q  <= back_prev;
				count_q <= count_q - 1'b1;
			end else if (rd_en && (req_type_q == REQ_POP_FRONT)) begin
				front_q <= front_next;
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rsp.data_out   = rd_valid_q ? rd_data_q : '0;
	assign rsp.status     = status_q;
	assign rsp.fill_count = 7'(count_q);

	logic [CNT_W:0] ptr_sum;
	logic [CNT_W:0] ptr_wrap;

	assign ptr_sum  = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(count_q);
	assign ptr_wrap = (ptr_sum >= (CNT_W + 1)'(DEPTH)) ? ptr_sum - (CNT_W + 1)'(DEPTH) : ptr_sum;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_wrap[PTR_W-1:0] == back_q)
		else $error("front, back and count disagree");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not advance count");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("read and write in one cycle");

endmodule
